@@ rtl/core/rpnc_pkg.sv @@
// Package for the RPN stack calculator core: sizes, token and status codes,
// and the request/response structs of the iterative divider.
// No dependencies.
package rpnc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;

    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 5;
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W    = $clog2(STACK_DEPTH);

    // divider: quotient bits, divisor 2*|a|, dividend |b| << (FRAC_BITS+1) plus |a|
    localparam int QUOT_W = 32;
    localparam int DEN_W  = DATA_W + 1;
    localparam int NUM_W  = DATA_W + FRAC_BITS + 2;
    localparam int CNT_W  = $clog2(QUOT_W);

    localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SAT     = 3'd5;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/core/rpnc_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module rpnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/rpnc_div.sv @@
// Restoring divider, one quotient bit per cycle, with an up-front overflow check.
// Depends on rpnc_pkg.
module rpnc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rpnc_pkg::t_div_req i_req,
    output rpnc_pkg::t_div_rsp o_rsp
);
    import rpnc_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quo;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    assign trial = {r_rem, r_quo[QUOT_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_req.den;
                r_rem  <= DEN_W'(i_req.num >> QUOT_W);
                r_quo  <= i_req.num[QUOT_W-1:0];
                // quotient of 2^QUOT_W or more: upper dividend already holds the divisor
                r_ovf  <= ((i_req.num >> QUOT_W) >= NUM_W'(i_req.den));
            end else if (r_busy) begin
                r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quo <= {r_quo[QUOT_W-2:0], fits};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_quo;

endmodule

@@ rtl/core/rpn_stack_calculator_core.sv @@
// RPN stack calculator core: stack sequencer, adder, multiplier, divider and result register.
// Depends on rpnc_pkg, rpnc_ram and rpnc_div.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pre-parsed token per
//   word: i_func selects push, add, sub, mult, div, clear or unknown, and
//   i_operand_value is the signed Q16.16 number for a push.
//   Output channel (o_out_valid / i_out_ready) returns one word per token: the
//   new top of stack (zero when empty), the stack depth and a status code.
//   The stack lives in a 16 x 32 synchronous RAM; the top entry is also held
//   in a register, so an operator needs one RAM read (the next entry) and one
//   write-back.
//   Push, add, sub, clear and unknown pass the load, execute and finish states
//   on the way to the result word; multiply adds a rounding state, and divide
//   waits for the divider (one quotient bit per cycle over 32 bits) unless the
//   divisor is zero. Tokens are handled one at a time; a new token is taken as
//   soon as the previous result sits in the output register, even if not yet taken.
//   Reset empties the stack (depth zero); RAM contents are not cleared.
//   When the receiver stalls, the finished result waits in the output register
//   and the following token holds before its commit until that register frees.
module rpn_stack_calculator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rpnc_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [rpnc_pkg::DATA_W-1:0]  i_operand_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rpnc_pkg::DATA_W-1:0]  o_top_value,
    output logic [rpnc_pkg::DEPTH_W-1:0]        o_stack_depth,
    output logic [rpnc_pkg::STATUS_W-1:0]       o_status
);
    import rpnc_pkg::*;

    localparam logic [63:0] MUL_RND = (64'd1 << FRAC_BITS) >> 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_MULR,
        S_DIVW,
        S_FIN
    } t_state;

    t_state r_state;

    // token and operands
    logic [FUNC_W-1:0]        r_func;
    logic signed [DATA_W-1:0] r_opnd;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_b;
    logic                     r_under;
    logic                     r_neg;
    logic [63:0]              r_prod;

    // stack state and pending commit
    logic [SP_W-1:0]          r_sp;
    logic signed [DATA_W-1:0] r_top;
    logic [SP_W-1:0]          r_new_sp;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_wr;
    logic [STATUS_W-1:0]      r_status;
    logic                     r_div_start;

    logic [DATA_W-1:0] mem_rdata;
    logic              mem_we;
    logic              out_free;
    logic [SP_W-1:0]   arith_sp;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [63:0]       mul_full;
    logic [63:0]       mul_round;
    logic [DATA_W:0]   sum_ab;
    logic [DATA_W:0]   diff_ba;
    logic [DATA_W:0]   add_res;
    logic [DATA_W:0]   sub_res;
    logic [DATA_W:0]   mul_res;
    logic [DATA_W:0]   div_res;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    // {saturated, value} of a 33-bit two's-complement result
    function automatic logic [DATA_W:0] clamp33(input logic [DATA_W:0] s);
        logic [DATA_W:0] res;
        if (s[DATA_W] != s[DATA_W-1]) begin
            res = s[DATA_W] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end else begin
            res = {1'b0, s[DATA_W-1:0]};
        end
        clamp33 = res;
    endfunction

    // {saturated, value} of a sign and a magnitude
    function automatic logic [DATA_W:0] clamp_mag(input logic neg, input logic [63:0] mag);
        logic [DATA_W:0] res;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, ~mag[DATA_W-1:0] + DATA_W'(1)};
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, mag[DATA_W-1:0]};
            end
        end
        clamp_mag = res;
    endfunction

    // stack RAM: next-to-top entry read every cycle, write-back at commit
    assign out_free = !o_out_valid || i_out_ready;
    assign mem_we   = (r_state == S_FIN) && out_free && r_wr;

    rpnc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (IDX_W'(r_new_sp - SP_W'(1))),
        .i_wdata (r_res),
        .i_raddr (IDX_W'(r_sp - SP_W'(2))),
        .o_rdata (mem_rdata)
    );

    // arithmetic
    assign mag_a     = mag32(r_a);
    assign mag_b     = mag32(r_b);
    assign mul_full  = {32'b0, mag_a} * {32'b0, mag_b};
    assign mul_round = (r_prod + MUL_RND) >> FRAC_BITS;
    assign sum_ab    = {r_a[DATA_W-1], r_a} + {r_b[DATA_W-1], r_b};
    assign diff_ba   = {r_b[DATA_W-1], r_b} - {r_a[DATA_W-1], r_a};
    assign add_res   = clamp33(sum_ab);
    assign sub_res   = clamp33(diff_ba);
    assign mul_res   = clamp_mag(r_neg, mul_round);
    assign div_res   = clamp_mag(r_neg, div_rsp.ovf ? '1 : {32'b0, div_rsp.quot});

    // an operator pops two (or what is there) and always pushes one
    assign arith_sp = ((r_sp >= SP_W'(2)) ? (r_sp - SP_W'(2)) : '0) + SP_W'(1);

    assign div_req.start = r_div_start;
    assign div_req.num   = (NUM_W'(mag_b) << (FRAC_BITS + 1)) + NUM_W'(mag_a);
    assign div_req.den   = {mag_a, 1'b0};

    rpnc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_top       <= '0;
            o_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_opnd  <= i_operand_value;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    // top from register, next entry from RAM; missing ones read as zero
                    r_a     <= (r_sp != '0) ? r_top : '0;
                    r_b     <= (r_sp >= SP_W'(2)) ? mem_rdata : '0;
                    r_under <= (r_sp < SP_W'(2));
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_neg    <= r_a[DATA_W-1] != r_b[DATA_W-1];
                    r_wr     <= 1'b1;
                    r_new_sp <= arith_sp;
                    r_state  <= S_FIN;
                    case (r_func)
                        FN_PUSH: begin
                            if (r_sp == SP_W'(STACK_DEPTH)) begin
                                // drop the word, stack unchanged
                                r_wr     <= 1'b0;
                                r_new_sp <= r_sp;
                                r_res    <= r_top;
                                r_status <= ST_FULL;
                            end else begin
                                r_new_sp <= r_sp + SP_W'(1);
                                r_res    <= r_opnd;
                                r_status <= ST_OK;
                            end
                        end
                        FN_ADD: begin
                            r_res    <= add_res[DATA_W-1:0];
                            r_status <= r_under ? ST_UNDER : (add_res[DATA_W] ? ST_SAT : ST_OK);
                        end
                        FN_SUB: begin
                            r_res    <= sub_res[DATA_W-1:0];
                            r_status <= r_under ? ST_UNDER : (sub_res[DATA_W] ? ST_SAT : ST_OK);
                        end
                        FN_MUL: begin
                            r_prod  <= mul_full;
                            r_state <= S_MULR;
                        end
                        FN_DIV: begin
                            if (r_a == '0) begin
                                // divide by zero: saturate by the sign of the dividend, zero for a zero dividend
                                if (r_b[DATA_W-1]) begin
                                    r_res <= 32'sh8000_0000;
                                end else if (r_b != '0) begin
                                    r_res <= 32'sh7FFF_FFFF;
                                end else begin
                                    r_res <= '0;
                                end
                                r_status <= r_under ? ST_UNDER : ST_DIVZ;
                            end else begin
                                r_div_start <= 1'b1;
                                r_state     <= S_DIVW;
                            end
                        end
                        FN_CLEAR: begin
                            r_wr     <= 1'b0;
                            r_new_sp <= '0;
                            r_res    <= '0;
                            r_status <= ST_OK;
                        end
                        default: begin
                            r_wr     <= 1'b0;
                            r_new_sp <= r_sp;
                            r_res    <= r_top;
                            r_status <= ST_UNKNOWN;
                        end
                    endcase
                end
                S_MULR: begin
                    // round to nearest, ties away from zero, then clamp
                    r_res    <= mul_res[DATA_W-1:0];
                    r_status <= r_under ? ST_UNDER : (mul_res[DATA_W] ? ST_SAT : ST_OK);
                    r_state  <= S_FIN;
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_res    <= div_res[DATA_W-1:0];
                        r_status <= r_under ? ST_UNDER : (div_res[DATA_W] ? ST_SAT : ST_OK);
                        r_state  <= S_FIN;
                    end
                end
                S_FIN: begin
                    // commit the stack and load the result word once the output register frees
                    if (out_free) begin
                        r_sp          <= r_new_sp;
                        r_top         <= r_res;
                        o_top_value   <= r_res;
                        o_stack_depth <= DEPTH_W'(r_new_sp);
                        o_status      <= r_status;
                        o_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/rpn_stack_calculator_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for rpn_stack_calculator_core: directed token table, then random tokens,
// each result word compared with the row's known word or with a shadow stack evaluated in the bench itself.
// Depends on rpnc_pkg and the core RTL.
module rpn_stack_calculator_core_tb;
    import rpnc_pkg::*;

    // Codes 6 and 7 are not named by the package; both must report an unknown word
    localparam logic [FUNC_W-1:0] FN_UNKNOWN = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE   = 3'd7;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam int RANDOM_TOKENS  = 1200;
    localparam int SEND_CALM_FROM = 500;   // random tokens offered back to back
    localparam int SEND_CALM_TO   = 720;
    localparam int SEND_DRAIN_AT  = 950;   // hold the input until the output is drained
    localparam int RECV_CALM_FROM = 560;   // result words taken without a gap
    localparam int RECV_CALM_TO   = 760;
    localparam int RECV_HOLD_AT   = 250;   // long hold-off on the output side
    localparam int RECV_HOLD_LEN  = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;  // hold-off plus several divides

    localparam logic [DATA_W-1:0] EXTREMES [5] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } t_word_out;

    // One directed row: token, repeat count, and where "known" is set the result word
    // read straight off the token sequence; other rows are scored by the shadow stack.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [DATA_W-1:0]   operand;
        logic [4:0]          reps;
        logic                known;
        logic [DATA_W-1:0]   top;
        logic [DEPTH_W-1:0]  depth;
        logic [STATUS_W-1:0] status;
    } t_row;

    localparam int N_ROWS = 41;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // empty stack: both operands missing, then clear and the two unknown codes
        '{FN_ADD,     32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd1,  ST_UNDER},
        '{FN_CLEAR,   32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_UNKNOWN, 32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_UNKNOWN},
        '{FN_SPARE,   32'hFFFF_FFFF, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_UNKNOWN},
        // saturation at both ends for add, at the top end for sub
        '{FN_PUSH,    32'h7FFF_FFFF, 5'd1,  1'b1, 32'h7FFF_FFFF, 5'd1,  ST_OK},
        '{FN_PUSH,    32'h7FFF_FFFF, 5'd1,  1'b1, 32'h7FFF_FFFF, 5'd2,  ST_OK},
        '{FN_ADD,     32'h0000_0000, 5'd1,  1'b1, 32'h7FFF_FFFF, 5'd1,  ST_SAT},
        '{FN_PUSH,    32'h8000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd2,  ST_OK},
        '{FN_SUB,     32'h0000_0000, 5'd1,  1'b1, 32'h7FFF_FFFF, 5'd1,  ST_SAT},
        '{FN_PUSH,    32'h8000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd2,  ST_OK},
        '{FN_PUSH,    32'h8000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd3,  ST_OK},
        '{FN_ADD,     32'h0000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd2,  ST_SAT},
        // divide by zero with a negative, a positive and a zero dividend; mult saturates low
        '{FN_PUSH,    32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd3,  ST_OK},
        '{FN_DIV,     32'h0000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd2,  ST_DIVZ},
        '{FN_MUL,     32'h0000_0000, 5'd1,  1'b1, 32'h8000_0000, 5'd1,  ST_SAT},
        '{FN_CLEAR,   32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0003_0000, 5'd1,  1'b1, 32'h0003_0000, 5'd1,  ST_OK},
        '{FN_PUSH,    32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd2,  ST_OK},
        '{FN_DIV,     32'h0000_0000, 5'd1,  1'b1, 32'h7FFF_FFFF, 5'd1,  ST_DIVZ},
        '{FN_PUSH,    32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd2,  ST_OK},
        '{FN_PUSH,    32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd3,  ST_OK},
        '{FN_DIV,     32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd2,  ST_DIVZ},
        // rounding: mixed signs, half-lsb ties away from zero, quotient tie
        '{FN_CLEAR,   32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0001_8000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'hFFFE_8000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_MUL,     32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0000_0001, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0000_8000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_MUL,     32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'hFFFF_FFFF, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0000_8000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_MUL,     32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0000_0001, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0002_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_DIV,     32'h0000_0000, 5'd1,  1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        // only one operand present
        '{FN_CLEAR,   32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h0005_0000, 5'd1,  1'b1, 32'h0005_0000, 5'd1,  ST_OK},
        '{FN_MUL,     32'h0000_0000, 5'd1,  1'b1, 32'h0000_0000, 5'd1,  ST_UNDER},
        // fill the stack, push once more onto a full stack, then pop from full
        '{FN_PUSH,    32'h0001_0000, 5'd16, 1'b0, 32'h0000_0000, 5'd0,  ST_OK},
        '{FN_PUSH,    32'h1234_5678, 5'd1,  1'b1, 32'h0001_0000, 5'd16, ST_FULL},
        '{FN_ADD,     32'h0000_0000, 5'd1,  1'b1, 32'h0002_0000, 5'd15, ST_OK}
    };

    logic                       i_clk           = 1'b0;
    logic                       i_rst_n         = 1'b0;
    logic                       i_in_valid      = 1'b0;
    logic                       o_in_ready;
    logic [FUNC_W-1:0]          i_func          = FN_PUSH;
    logic signed [DATA_W-1:0]   i_operand_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready     = 1'b0;
    logic signed [DATA_W-1:0]   o_top_value;
    logic [DEPTH_W-1:0]         o_stack_depth;
    logic [STATUS_W-1:0]        o_status;

    // Shadow of the block's stack, and the result words still owed by the block
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned       shadow_depth = 0;
    t_word_out         pending_words [$];
    int unsigned       fail_count = 0;

    rpn_stack_calculator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_top_value     (o_top_value),
        .o_stack_depth   (o_stack_depth),
        .o_status        (o_status)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Clamp a wide signed sum to 32 bits; bit 32 of the return flags saturation
    function automatic logic [DATA_W:0] clamp_wide(input longint x);
        if (x > S32_MAX) return {1'b1, 32'h7FFF_FFFF};
        if (x < S32_MIN) return {1'b1, 32'h8000_0000};
        return {1'b0, x[DATA_W-1:0]};
    endfunction

    // Clamp sign plus magnitude to 32 bits; bit 32 flags saturation
    function automatic logic [DATA_W:0] clamp_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] twos;
        if (neg) begin
            if (mag > 64'd2147483648) return {1'b1, 32'h8000_0000};
            twos = 64'd0 - mag;
            return {1'b0, twos[DATA_W-1:0]};
        end
        if (mag > 64'd2147483647) return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, mag[DATA_W-1:0]};
    endfunction

    // Evaluate one token on the shadow stack and return the word the block owes for it
    function automatic t_word_out apply_token(input logic [FUNC_W-1:0] fn,
                                              input logic [DATA_W-1:0] value);
        t_word_out   res;
        longint      a, b;
        logic        have_a, have_b, neg;
        logic [63:0] ma, mb, scaled;
        logic [DATA_W:0] packed_res;
        res.status = ST_OK;
        if (fn == FN_PUSH) begin
            if (shadow_depth >= STACK_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                shadow_stack[shadow_depth] = value;
                shadow_depth++;
            end
        end else if (fn == FN_CLEAR) begin
            shadow_depth = 0;
        end else if (fn >= FN_ADD && fn <= FN_DIV) begin
            // pop a from the top, then b; a missing entry reads as zero
            have_a = (shadow_depth != 0);
            a = 0;
            if (have_a) begin
                shadow_depth--;
                a = $signed(shadow_stack[shadow_depth]);
            end
            have_b = (shadow_depth != 0);
            b = 0;
            if (have_b) begin
                shadow_depth--;
                b = $signed(shadow_stack[shadow_depth]);
            end
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            neg = (a < 0) != (b < 0);
            case (fn)
                FN_ADD: packed_res = clamp_wide(a + b);
                FN_SUB: packed_res = clamp_wide(b - a);
                FN_MUL: begin
                    scaled = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    packed_res = clamp_mag(neg, scaled);
                end
                default: begin
                    if (a == 0) begin
                        packed_res = {1'b0, (b > 0) ? 32'h7FFF_FFFF :
                                            (b < 0) ? 32'h8000_0000 : 32'h0000_0000};
                    end else begin
                        // round to nearest, ties away from zero: ((|b| << (FRAC_BITS+1)) + |a|) / 2|a|
                        scaled = ((mb << (FRAC_BITS + 1)) + ma) / (ma << 1);
                        packed_res = clamp_mag(neg, scaled);
                    end
                end
            endcase
            shadow_stack[shadow_depth] = packed_res[DATA_W-1:0];
            shadow_depth++;
            if (!have_a || !have_b)       res.status = ST_UNDER;
            else if (fn == FN_DIV && a == 0) res.status = ST_DIVZ;
            else if (packed_res[DATA_W])  res.status = ST_SAT;
        end else begin
            res.status = ST_UNKNOWN;
        end
        res.top   = (shadow_depth > 0) ? shadow_stack[shadow_depth - 1] : '0;
        res.depth = shadow_depth[DEPTH_W-1:0];
        return res;
    endfunction

    // Offer one token word and hold it until taken. Where a gap or a drain is due, valid drops
    // first and is sampled low before it rises again, so valid never falls and rises in the same step.
    task automatic put_token(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] value,
                             input logic known, input t_word_out known_word,
                             input logic allow_gaps, input logic drain_first);
        t_word_out predicted;
        if (drain_first || (allow_gaps && $urandom_range(0, 99) < 25)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (drain_first && pending_words.size() != 0) @(posedge i_clk);
            while (allow_gaps && $urandom_range(0, 99) < 25) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= fn;
        i_operand_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // word taken at this edge: advance the shadow stack and log what is owed
        predicted = apply_token(fn, value);
        pending_words.push_back(known ? known_word : predicted);
    endtask

    // Stimulus: reset, the directed table, then the random tokens
    initial begin : token_source
        int          row, rep, n;
        t_row        cur;
        t_word_out   known_word;
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] value;
        logic        filling;
        int unsigned pick, push_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++) begin
            cur = DIRECTED_ROWS[row];
            known_word = '{top: cur.top, depth: cur.depth, status: cur.status};
            for (rep = 0; rep < cur.reps; rep++) begin
                put_token(cur.func, cur.operand, cur.known, known_word, 1'b1, 1'b0);
            end
        end

        // Pick a filling or draining phase at random every 60 tokens so the stack swings between
        // empty (underflow) and full, with clears and unknown words mixed in
        filling = 1'b1;
        for (n = 0; n < RANDOM_TOKENS; n++) begin
            if (n % 60 == 0) filling = $urandom_range(0, 1);
            push_pct = filling ? 70 : 30;
            pick = $urandom_range(0, 99);
            if (pick < push_pct)  fn = FN_PUSH;
            else if (pick < 90)   fn = 3'($urandom_range(FN_ADD, FN_DIV));
            else if (pick < 95)   fn = FN_CLEAR;
            else                  fn = $urandom_range(0, 1) ? FN_UNKNOWN : FN_SPARE;

            case ($urandom_range(0, 5))
                0, 1: value = $urandom;
                2: value = 32'(($urandom_range(0, 16) - 8) * 65536);
                3: begin
                    value = $urandom_range(0, 65535);
                    if (value[15]) value[31:16] = 16'hFFFF;
                end
                4: value = EXTREMES[$urandom_range(0, 4)];
                default: begin
                    value = $urandom_range(0, 32'h000F_FFFF);
                    if ($urandom_range(0, 1) == 1) value = -value;
                end
            endcase

            put_token(fn, value, 1'b0, '0,
                      !(n >= SEND_CALM_FROM && n < SEND_CALM_TO), n == SEND_DRAIN_AT);
        end

        // drop valid, let the block drain, then idle for TAIL_CYCLES before ending
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rpn_stack_calculator_core verification clean");
        end else begin
            $display("rpn_stack_calculator_core verification failed");
        end
        $finish;
    end

    // Result side: take words, compare with the oldest owed word, drive ready
    initial begin : result_sink
        int unsigned seen, hold_left;
        t_word_out   want;
        seen = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: result word with nothing owed: top %h depth %0d status %0d",
                             $time, o_top_value, o_stack_depth, o_status);
                    fail_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (o_top_value !== want.top) begin
                        $display("%0t: top_value expected %h, got %h",
                                 $time, want.top, o_top_value);
                        fail_count++;
                    end
                    if (o_stack_depth !== want.depth) begin
                        $display("%0t: stack_depth expected %0d, got %0d",
                                 $time, want.depth, o_stack_depth);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, o_status);
                        fail_count++;
                    end
                end
                seen++;
                // long hold-off: the block fills its output register and stalls its input
                if (seen == RECV_HOLD_AT) hold_left = RECV_HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (seen >= RECV_CALM_FROM && seen < RECV_CALM_TO) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long
    initial begin : stall_watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid === 1'b1 && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("rpn_stack_calculator_core verification failed");
        $finish;
    end

endmodule

@@ rpn_stack_calculator_core.f @@
rtl/core/rpnc_pkg.sv
rtl/core/rpnc_ram.sv
rtl/core/rpnc_div.sv
rtl/core/rpn_stack_calculator_core.sv
tb/sv/rpn_stack_calculator_core_tb.sv
